// ----- hdl/mbr_pkg.sv -----
// Shared types and constants of the MSB-first bit repacker.
// Used by the top level, the word slicer and the port checker.
package mbr_pkg;

    // Field and store sizes
    localparam int WORD_W        = 32;
    localparam int STORE_BITS    = 39;
    localparam int HELD_W        = 6;
    localparam int WIDTH_W       = 6;
    localparam int LIMIT_W       = 16;
    localparam int RESULT_CAP    = 8;
    localparam int CNT_W         = 3;
    localparam int MAX_WORD_BITS = 32;

    // Largest usable word width
    localparam int WIDTH_CAP = (MAX_WORD_BITS < WORD_W) ? MAX_WORD_BITS : WORD_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_LIMIT = 2'd1;

    // Register reset values
    localparam logic [WIDTH_W-1:0] WORD_BITS_RST  = 6'd10;
    localparam logic [LIMIT_W-1:0] WORD_LIMIT_RST = 16'hFFFF;

    // One slice taken from the head of the bit store
    typedef struct packed {
        logic [WORD_W-1:0] word;    // earliest bits, right-aligned
        logic [HELD_W-1:0] rest;    // bits left after the slice
        logic              enough;  // store holds a full word
    } t_slice;

endpackage

// ----- hdl/mbr_slicer.sv -----
// Word slicer: cuts the earliest word off the bit store.
// Depends on mbr_pkg.
module mbr_slicer
    import mbr_pkg::*;
(
    input  logic [STORE_BITS-1:0] i_store,
    input  logic [HELD_W-1:0]     i_held,
    input  logic [WIDTH_W-1:0]    i_width,
    output t_slice                o_slice
);

    logic [STORE_BITS-1:0] shifted;
    logic [WORD_W-1:0]     word_mask;

    // Align the head of the store and keep only the word width
    always_comb begin
        o_slice.enough = (i_held >= i_width);
        o_slice.rest   = i_held - i_width;
        shifted        = i_store >> o_slice.rest;
        if (i_width >= WIDTH_W'(WORD_W)) begin
            word_mask = '1;
        end else begin
            word_mask = (WORD_W'(1) << i_width) - WORD_W'(1);
        end
        o_slice.word = shifted[WORD_W-1:0] & word_mask;
    end

endmodule

// ----- hdl/msb_first_bit_repacker.sv -----
// Top level of the MSB-first bit repacker: byte input, word output, config port.
// Depends on mbr_pkg and mbr_slicer.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one byte per beat, bit 7
//   first; i_frame_start clears leftover bits and the word count before it.
//   Output channel (o_out_valid / i_out_ready) gives one word per beat,
//   earliest bit in the MSB of the word_bits-wide field, with o_run_last on the
//   last word of each byte and o_frame_end on the word that reaches the limit.
//   Config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
//   (0 word_bits, 1 word_limit), only while the block is idle.
// Timing:
//   A byte enters the work register at acceptance; its words are sliced from
//   the store into the output register, one per cycle while the receiver takes
//   them, and the next byte can be taken as the last word is sliced; at widths
//   of eight or more a byte is taken every cycle unless the receiver stalls. The
//   single output register and one slice per cycle from the store set that rate.
// Reset: synchronous, active low; clears the store, the counts, the output
//   valid and sets word_bits 10, word_limit 65535.
// Stall: while the receiver holds i_out_ready low the output word holds and
//   the work register stops; the input is refused once the byte in work has
//   more words to give.
module msb_first_bit_repacker
    import mbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_start,
    // word output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_word,
    output logic                 o_run_last,
    output logic                 o_frame_end
);

    logic [WIDTH_W-1:0]    r_word_bits;
    logic [LIMIT_W-1:0]    r_word_limit;
    logic [STORE_BITS-1:0] r_store, n_store;
    logic [HELD_W-1:0]     r_held, n_held;
    logic [LIMIT_W-1:0]    r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_ovalid;
    logic [WORD_W-1:0]     r_oword;
    logic                  r_olast;
    logic                  r_oend;

    logic [WIDTH_W-1:0]    eff_w;
    t_slice                slice;
    logic [LIMIT_W-1:0]    done_inc;
    logic                  hit_end;
    logic                  is_last;
    logic                  can_emit;
    logic                  out_free;
    logic                  emit;
    logic                  finish;
    logic                  in_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bits  <= WORD_BITS_RST;
            r_word_limit <= WORD_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WORD_BITS:  r_word_bits  <= i_cfg_data[WIDTH_W-1:0];
                REG_WORD_LIMIT: r_word_limit <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp the width to 1..WIDTH_CAP
    always_comb begin
        if (r_word_bits == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (r_word_bits > WIDTH_W'(WIDTH_CAP)) begin
            eff_w = WIDTH_W'(WIDTH_CAP);
        end else begin
            eff_w = r_word_bits;
        end
    end

    mbr_slicer u_slicer (
        .i_store (r_store),
        .i_held  (r_held),
        .i_width (eff_w),
        .o_slice (slice)
    );

    // Emit and handshake control
    always_comb begin
        done_inc = r_done + LIMIT_W'(1);
        hit_end  = (done_inc == r_word_limit);
        is_last  = hit_end || (r_cnt == CNT_W'(RESULT_CAP - 1)) || (slice.rest < eff_w);
        can_emit = r_busy && slice.enough && (r_done < r_word_limit);
        out_free = !r_ovalid || i_out_ready;
        emit     = can_emit && out_free;
        finish   = r_busy && (!can_emit || (emit && is_last));
        o_in_ready = !r_busy || finish;
        in_take  = i_in_valid && o_in_ready;
    end

    // Work register next state: slice first, then append an accepted byte
    always_comb begin
        n_store = r_store;
        n_held  = r_held;
        n_done  = r_done;
        n_cnt   = r_cnt;
        n_busy  = r_busy;

        if (emit) begin
            n_held  = slice.rest;
            n_store = r_store & ((STORE_BITS'(1) << slice.rest) - STORE_BITS'(1));
            n_done  = done_inc;
            n_cnt   = r_cnt + CNT_W'(1);
            if (hit_end) begin
                n_store = '0;
                n_held  = '0;
            end
        end
        if (finish) begin
            n_busy = 1'b0;
        end

        if (in_take) begin
            if (i_frame_start) begin
                n_store = '0;
                n_held  = '0;
                n_done  = '0;
            end
            if (n_done >= r_word_limit) begin
                // frame is full: drop the byte and the leftover bits
                n_store = '0;
                n_held  = '0;
                n_busy  = 1'b0;
            end else begin
                n_store = {n_store[STORE_BITS-9:0], i_data_byte};
                n_held  = n_held + HELD_W'(8);
                n_cnt   = '0;
                n_busy  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_held  <= '0;
            r_done  <= '0;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_store <= n_store;
            r_held  <= n_held;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
        end
    end

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oword <= slice.word;
            r_olast <= is_last;
            r_oend  <= hit_end;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_word      = r_oword;
    assign o_run_last  = r_olast;
    assign o_frame_end = r_oend;

endmodule

// ----- hdl/mbr_checker.sv -----
// Port checker for the MSB-first bit repacker, bound to the top level.
// Depends on mbr_pkg; watches the top-level ports only.
module mbr_checker
    import mbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [WORD_W-1:0]    o_word,
    input  logic                 o_run_last,
    input  logic                 o_frame_end
);

    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled beat
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_word) && $stable(o_run_last)
            && $stable(o_frame_end))
        else $error("output beat changed while stalled");

    // The word that closes a frame is always the last of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_run_last)
        else $error("frame end without run last");

endmodule

bind msb_first_bit_repacker mbr_checker u_mbr_checker (.*);

// ----- tb/msb_first_bit_repacker_tb.sv -----
// Testbench for msb_first_bit_repacker: byte beats in, word beats out, each word checked
// against a bit-exact gearbox model kept in a small scoreboard class.
// Depends on mbr_pkg and the repacker RTL.
module msb_first_bit_repacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbr_pkg::*;

    localparam int SETTLE_CYCLES   = 16;   // lets a byte drain from work and the output reg
    localparam int RANDOM_BYTES    = 180;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AFTER  = 80;   // words seen before the long receiver stall

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              run_last;
        logic              frame_end;
    } t_word_beat;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte;
    logic                 i_frame_start;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [WORD_W-1:0]    o_word;
    logic                 o_run_last;
    logic                 o_frame_end;

    // Gearbox model: bit store, word count and registers, plus the words still owed
    class word_tracker;
        logic [WIDTH_W-1:0]    width_reg;
        logic [LIMIT_W-1:0]    limit_reg;
        logic [STORE_BITS-1:0] store;
        int unsigned           held;
        logic [LIMIT_W-1:0]    words_done;
        t_word_beat            pending[$];
        int unsigned           errors;

        function new();
            width_reg  = WORD_BITS_RST;
            limit_reg  = WORD_LIMIT_RST;
            store      = '0;
            held       = 0;
            words_done = '0;
            errors     = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [LIMIT_W-1:0] value);
            case (idx)
                REG_WORD_BITS:  width_reg = value[WIDTH_W-1:0];
                REG_WORD_LIMIT: limit_reg = value;
                default: ;
            endcase
        endfunction

        // Append one byte and queue the words it completes; return 0 if the byte is dropped
        function bit take_byte(input logic [7:0] data, input logic start);
            int unsigned w;
            int unsigned rest;
            int unsigned n;
            logic [63:0] head;
            logic [63:0] keep;
            t_word_beat  beat;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > WIDTH_CAP) w = WIDTH_CAP;
            if (start) begin
                store      = '0;
                held       = 0;
                words_done = '0;
            end
            // drop bytes once the frame has its words
            if (words_done >= limit_reg) begin
                store = '0;
                held  = 0;
                return 1'b0;
            end
            store = {store[STORE_BITS-9:0], data};
            held += 8;
            n = 0;
            // slice at most eight words, earliest bits first
            while (n < RESULT_CAP && held >= w && words_done < limit_reg) begin
                rest = held - w;
                head = ({25'd0, store} >> rest) & ((64'd1 << w) - 64'd1);
                keep = (64'd1 << rest) - 64'd1;
                beat.word     = head[WORD_W-1:0];
                beat.run_last = 1'b0;
                held  = rest;
                store = store & keep[STORE_BITS-1:0];
                words_done = words_done + LIMIT_W'(1);
                beat.frame_end = (words_done == limit_reg);
                pending.push_back(beat);
                n++;
                if (beat.frame_end) begin
                    store = '0;
                    held  = 0;
                end
            end
            if (n > 0) pending[pending.size()-1].run_last = 1'b1;
            return 1'b1;
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        // Compare one output beat with the oldest owed word
        task check_word(input logic [WORD_W-1:0] word, input logic last, input logic fend);
            t_word_beat want;
            if (pending.size() == 0) begin
                report($sformatf("word %h arrived with nothing owed", word));
                return;
            end
            want = pending.pop_front();
            if (word !== want.word)
                report($sformatf("word %h, want %h", word, want.word));
            if (last !== want.run_last)
                report($sformatf("run_last %b, want %b (word %h)", last, want.run_last,
                                 want.word));
            if (fend !== want.frame_end)
                report($sformatf("frame_end %b, want %b (word %h)", fend, want.frame_end,
                                 want.word));
        endtask
    endclass

    word_tracker tracker = new();
    int unsigned bytes_used;
    int unsigned words_seen;
    int unsigned burst_left;
    bit          gaps_on;

    msb_first_bit_repacker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word       (o_word),
        .o_run_last   (o_run_last),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_word(o_word, o_run_last, o_frame_end);
            words_seen++;
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off while bytes keep coming
    initial begin
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          held_once;
        i_out_ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && i_in_valid && words_seen >= HOLD_OFF_AFTER
                    && tracker.pending.size() != 0) begin
                held_once = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_out_ready = 1'b1;
                    RX_MOSTLY: i_out_ready = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: i_out_ready = ($urandom_range(0, 9) < 3);
                    default:   i_out_ready = mode_left[2];
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one byte beat in the sender's burst pattern; hold it until accepted
    task automatic send_byte(input logic [7:0] data, input logic start);
        if (gaps_on && burst_left == 0) begin
            i_in_valid    = 1'b0;
            i_data_byte   = 8'($urandom);
            i_frame_start = 1'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left != 0) burst_left--;
        i_in_valid    = 1'b1;
        i_data_byte   = data;
        i_frame_start = start;
        do @(posedge i_clk); while (!o_in_ready);
        void'(tracker.take_byte(data, start));
        bytes_used++;
        @(negedge i_clk);
    endtask

    // Wait until every owed word is out and the work register has drained
    task automatic settle();
        i_in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.write_reg(idx, value);
    endtask

    initial begin
        int unsigned        taken_at_start;
        int unsigned        phase_len;
        int unsigned        frame_left;
        logic [WIDTH_W-1:0] width;
        logic [LIMIT_W-1:0] limit;
        logic               start;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_WORD_BITS;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        bytes_used    = 0;
        words_seen    = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset widths: 10-bit words, limit of 65535 words
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);

        // Width 1: eight words per byte
        settle();
        write_reg(REG_WORD_BITS, 16'd1);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);

        // Width zero behaves as one
        settle();
        write_reg(REG_WORD_BITS, 16'd0);
        send_byte(8'hC3, 1'b1);

        // Width above the cap behaves as 32
        settle();
        write_reg(REG_WORD_BITS, 16'd63);
        send_byte(8'hDE, 1'b1);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);

        // Zero limit: nothing comes out of the frame
        settle();
        write_reg(REG_WORD_BITS, 16'd13);
        write_reg(REG_WORD_LIMIT, 16'd0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);

        // Limit reached: rest of frame dropped, next frame starts fresh
        settle();
        write_reg(REG_WORD_BITS, 16'd4);
        write_reg(REG_WORD_LIMIT, 16'd2);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);

        // Width lowered mid-frame: 32 bits held, only eight words leave per byte
        settle();
        write_reg(REG_WORD_BITS, 16'd32);
        write_reg(REG_WORD_LIMIT, 16'hFFFF);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        settle();
        write_reg(REG_WORD_BITS, 16'd1);
        send_byte(8'h55, 1'b0);

        // Limit lowered under the count mid-frame: byte ignored, store cleared
        settle();
        write_reg(REG_WORD_BITS, 16'd8);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        settle();
        write_reg(REG_WORD_LIMIT, 16'd1);
        send_byte(8'h99, 1'b0);
        send_byte(8'h66, 1'b1);

        // Random phases: mostly well-formed frames, some carried-over state and stray starts
        taken_at_start = bytes_used;
        while (bytes_used - taken_at_start < RANDOM_BYTES) begin
            settle();
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(0, 1) ? 6'($urandom_range(33, 63)) : 6'd0;
                1, 2:    width = 6'($urandom_range(1, 7));
                default: width = 6'($urandom_range(8, 32));
            endcase
            case ($urandom_range(0, 9))
                0:          limit = 16'd0;
                1:          limit = 16'd1;
                2, 3, 4, 5: limit = 16'($urandom_range(2, 12));
                6:          limit = 16'($urandom_range(13, 65534));
                default:    limit = 16'hFFFF;
            endcase
            write_reg(REG_WORD_BITS, {10'd0, width});
            write_reg(REG_WORD_LIMIT, limit);
            gaps_on    = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(15, 35);
            frame_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
            for (int i = 0; i < phase_len; i++) begin
                start = 1'b0;
                if (frame_left == 0) begin
                    start      = 1'b1;
                    frame_left = $urandom_range(1, 16);
                end else if ($urandom_range(0, 19) == 0) begin
                    start = 1'b1;
                end
                frame_left--;
                send_byte(8'($urandom), start);
            end
        end

        settle();
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
